@@ hdl/three_level_feedback_scheduler_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_CORE_MACROS_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TLFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlfs assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TLFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlfs assertion failed");

`endif

@@ hdl/tlfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tlfs_pkg
// Types and codes of the three-level feedback scheduler.
// ----------------------------------------------------------------------------
package tlfs_pkg;

    // Command codes of an input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_QUANTUM_ONE = 1'b0;
    localparam logic CFG_QUANTUM_TWO = 1'b1;

    // Queue codes: three ready levels and the I/O wait queue.
    localparam logic [1:0] Q_TOP  = 2'd0;
    localparam logic [1:0] Q_MID  = 2'd1;
    localparam logic [1:0] Q_BOT  = 2'd2;
    localparam logic [1:0] Q_WAIT = 2'd3;

    // Destination codes of a result word.
    localparam logic [2:0] DEST_WAIT = 3'd0;
    localparam logic [2:0] DEST_TERM = 3'd4;

    // Reset values of the quanta.
    localparam logic [7:0] QUANTUM_ONE_RESET = 8'd6;
    localparam logic [7:0] QUANTUM_TWO_RESET = 8'd11;

    typedef struct packed {
        logic       command;
        logic [2:0] process_id;
        logic [4:0] burst_index;
        logic [9:0] burst_length;
        logic       last_burst;
    } t_in_word;

    typedef struct packed {
        logic       ran;
        logic [2:0] served_process;
        logic       was_io;
        logic [1:0] served_level;
        logic [9:0] run_amount;
        logic [2:0] destination;
        logic [5:0] next_burst_index;
    } t_out_word;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic pop;
        logic exec;
        logic idle;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic can_pop;
        logic live;
        logic out_full;
    } t_status;

endpackage

@@ hdl/tlfs_in_if.sv @@
// ----------------------------------------------------------------------------
// tlfs_in_if
// Input channel: valid, ready and one input word.
// ----------------------------------------------------------------------------
interface tlfs_in_if;
    logic               valid;
    logic               ready;
    tlfs_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tlfs_out_if.sv @@
// ----------------------------------------------------------------------------
// tlfs_out_if
// Output channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface tlfs_out_if;
    logic                valid;
    logic                ready;
    tlfs_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tlfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlfs_ctrl
// Step sequencer: accept, pop and skip finished processes, execute.
// ----------------------------------------------------------------------------
module tlfs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_command,
    input  tlfs_pkg::t_status   i_status,
    output logic                o_in_ready,
    output tlfs_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_idle, n_idle;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Commands follow from the state and the datapath status.
    always_comb begin
        n_state    = r_state;
        n_idle     = r_idle;
        o_cmd      = '0;
        o_cmd.idle = r_idle;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_command == tlfs_pkg::CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        n_state = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                if (!i_status.can_pop) begin
                    n_idle  = 1'b1;
                    n_state = ST_EXEC;
                end else begin
                    o_cmd.pop = 1'b1;
                    if (i_status.live) begin
                        n_idle  = 1'b0;
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (!i_status.out_full) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and the idle-result flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idle  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idle  <= n_idle;
        end
    end

endmodule

@@ hdl/tlfs_dpath.sv @@
// ----------------------------------------------------------------------------
// tlfs_dpath
// Burst store, process tables, four queues, quanta and output register.
// ----------------------------------------------------------------------------
module tlfs_dpath #(
    parameter int NUM_PROCESSES = 8,
    parameter int MAX_BURSTS    = 32,
    parameter int BURST_WIDTH   = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlfs_pkg::t_in_word  i_in_data,
    input  tlfs_pkg::t_cmd      i_cmd,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_out_ready,
    output tlfs_pkg::t_status   o_status,
    output logic                o_out_valid,
    output tlfs_pkg::t_out_word o_out_data
);

    localparam int PW  = $clog2(NUM_PROCESSES);
    localparam int BW  = $clog2(MAX_BURSTS);
    localparam int PSW = $clog2(MAX_BURSTS + 1);
    localparam int CW  = $clog2(NUM_PROCESSES + 1);
    localparam int AW  = $clog2(NUM_PROCESSES * MAX_BURSTS);
    localparam int SW  = (BURST_WIDTH > 8) ? BURST_WIDTH : 8;
    localparam int IPW = (PW > 3) ? PW : 3;
    localparam int IBW = (BW > 5) ? BW : 5;
    localparam int LW  = (BURST_WIDTH > 10) ? BURST_WIDTH : 10;
    localparam int DEPTH = NUM_PROCESSES * MAX_BURSTS;

    localparam logic [1:0] Q_TOP = tlfs_pkg::Q_TOP;
    localparam logic [1:0] Q_MID = tlfs_pkg::Q_MID;
    localparam logic [1:0] Q_BOT = tlfs_pkg::Q_BOT;

    // Storage.
    logic [BURST_WIDTH-1:0] mem [DEPTH];
    logic [BURST_WIDTH-1:0] r_rdata;
    logic [PSW-1:0]         r_total [NUM_PROCESSES];
    logic [PSW-1:0]         r_pos   [NUM_PROCESSES];
    logic [1:0]             r_level [NUM_PROCESSES];
    logic [PW-1:0]          r_slot  [4][NUM_PROCESSES];
    logic [PW-1:0]          r_head  [4];
    logic [PW-1:0]          r_tail  [4];
    logic [CW-1:0]          r_count [4];
    logic                   r_drain;
    logic [7:0]             r_q1, r_q2;
    logic [PW-1:0]          r_pid;
    logic [AW-1:0]          r_addr;
    logic                   r_out_valid;
    tlfs_pkg::t_out_word    r_out_data;

    // Load decode.
    logic [IPW-1:0]         ld_pid_ext;
    logic [IBW-1:0]         ld_idx_ext;
    logic [PW-1:0]          ld_pid;
    logic [BW-1:0]          ld_idx;
    logic                   ld_ok;
    logic [AW-1:0]          ld_addr;

    assign ld_pid_ext = IPW'(i_in_data.process_id);
    assign ld_idx_ext = IBW'(i_in_data.burst_index);
    assign ld_pid     = ld_pid_ext[PW-1:0];
    assign ld_idx     = ld_idx_ext[BW-1:0];
    assign ld_ok      = i_cmd.load
                        && (int'(i_in_data.process_id) < NUM_PROCESSES)
                        && (int'(i_in_data.burst_index) < MAX_BURSTS);
    assign ld_addr    = AW'(int'(ld_pid) * MAX_BURSTS + int'(ld_idx));

    // Queue selection: first non-empty ready level unless draining I/O.
    logic       sel_ready;
    logic [1:0] sel_q, pop_q;
    logic [PW-1:0] ppid;

    always_comb begin
        sel_ready = !r_drain;
        if (r_count[Q_TOP] != '0) begin
            sel_q = tlfs_pkg::Q_TOP;
        end else if (r_count[Q_MID] != '0) begin
            sel_q = tlfs_pkg::Q_MID;
        end else if (r_count[Q_BOT] != '0) begin
            sel_q = tlfs_pkg::Q_BOT;
        end else begin
            sel_q     = tlfs_pkg::Q_TOP;
            sel_ready = 1'b0;
        end
    end

    assign pop_q = sel_ready ? sel_q : tlfs_pkg::Q_WAIT;
    assign ppid  = r_slot[pop_q][r_head[pop_q]];

    assign o_status.can_pop  = sel_ready || (r_count[tlfs_pkg::Q_WAIT] != '0);
    assign o_status.live     = r_pos[ppid] < r_total[ppid];
    assign o_status.out_full = r_out_valid;

    // Execution of the picked burst.
    logic [PSW-1:0]         x_pos, x_npos;
    logic [1:0]             x_lvl, x_nlvl, x_q;
    logic [SW-1:0]          x_data, x_qv, x_rem;
    logic [LW-1:0]          x_run;
    logic                   x_io, x_wb;
    logic [2:0]             x_dest;
    logic                   x_push;

    always_comb begin
        x_pos  = r_pos[r_pid];
        x_lvl  = r_level[r_pid];
        x_data = SW'(r_rdata);
        x_qv   = (x_lvl == Q_TOP) ? SW'(r_q1) : SW'(r_q2);
        x_rem  = (x_data > x_qv) ? (x_data - x_qv) : '0;
        x_io   = x_pos[0];
        x_wb   = 1'b0;
        x_npos = x_pos + PSW'(1);
        x_nlvl = x_lvl;
        x_run  = LW'(r_rdata);
        if (!x_io && (x_lvl == Q_TOP || x_lvl == Q_MID)) begin
            x_wb  = 1'b1;
            x_run = LW'(x_qv);
            if (x_rem != '0) begin
                x_npos = x_pos;
                x_nlvl = x_lvl + 2'd1;
            end
        end
        x_q    = (x_nlvl == Q_TOP || x_nlvl == Q_MID) ? x_nlvl : Q_BOT;
        x_push = 1'b1;
        if (x_npos >= r_total[r_pid]) begin
            x_dest = tlfs_pkg::DEST_TERM;
            x_push = 1'b0;
        end else if (x_npos[0]) begin
            x_dest = tlfs_pkg::DEST_WAIT;
            x_q    = tlfs_pkg::Q_WAIT;
        end else begin
            x_dest = 3'(x_q) + 3'd1;
        end
    end

    logic exec_run;
    assign exec_run = i_cmd.exec && !i_cmd.idle;

    // Queue push: a load of a last burst enqueues at the top, an execution routes onward.
    logic          push_en;
    logic [1:0]    push_q;
    logic [PW-1:0] push_pid;

    always_comb begin
        if (ld_ok && i_in_data.last_burst) begin
            push_en  = 1'b1;
            push_q   = Q_TOP;
            push_pid = ld_pid;
        end else begin
            push_en  = exec_run && x_push;
            push_q   = x_q;
            push_pid = r_pid;
        end
    end

    // Burst store with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (ld_ok) begin
            mem[ld_addr] <= BURST_WIDTH'(i_in_data.burst_length);
        end else if (exec_run && x_wb) begin
            mem[r_addr] <= x_rem[BURST_WIDTH-1:0];
        end
        if (i_cmd.pop) begin
            r_rdata <= mem[AW'(int'(ppid) * MAX_BURSTS + int'(r_pos[ppid][BW-1:0]))];
            r_addr  <= AW'(int'(ppid) * MAX_BURSTS + int'(r_pos[ppid][BW-1:0]));
            r_pid   <= ppid;
        end
    end

    // Queue slots.
    always_ff @(posedge i_clk) begin
        if (push_en && (int'(r_count[push_q]) < NUM_PROCESSES)) begin
            r_slot[push_q][r_tail[push_q]] <= push_pid;
        end
    end

    // Queue pointers, drain mode and process tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < 4; q++) begin
                r_head[q]  <= '0;
                r_tail[q]  <= '0;
                r_count[q] <= '0;
            end
            for (int p = 0; p < NUM_PROCESSES; p++) begin
                r_total[p] <= '0;
                r_pos[p]   <= '0;
                r_level[p] <= '0;
            end
            r_drain <= 1'b0;
        end else begin
            for (int q = 0; q < 4; q++) begin
                if (push_en && (push_q == 2'(q))
                        && (int'(r_count[q]) < NUM_PROCESSES)) begin
                    r_tail[q]  <= (int'(r_tail[q]) == NUM_PROCESSES - 1)
                                  ? '0 : r_tail[q] + PW'(1);
                    r_count[q] <= r_count[q] + CW'(1);
                end
                if (i_cmd.pop && (pop_q == 2'(q))) begin
                    r_head[q]  <= (int'(r_head[q]) == NUM_PROCESSES - 1)
                                  ? '0 : r_head[q] + PW'(1);
                    r_count[q] <= r_count[q] - CW'(1);
                end
            end
            if (i_cmd.pop) begin
                if (sel_ready) begin
                    r_level[ppid] <= sel_q;
                end else begin
                    r_drain <= (r_count[tlfs_pkg::Q_WAIT] != CW'(1));
                end
            end
            if (ld_ok && i_in_data.last_burst) begin
                r_total[ld_pid] <= PSW'(int'(ld_idx) + 1);
                r_pos[ld_pid]   <= '0;
                r_level[ld_pid] <= Q_TOP;
            end
            if (exec_run) begin
                r_pos[r_pid]   <= x_npos;
                r_level[r_pid] <= x_nlvl;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1 <= tlfs_pkg::QUANTUM_ONE_RESET;
            r_q2 <= tlfs_pkg::QUANTUM_TWO_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == tlfs_pkg::CFG_QUANTUM_ONE) begin
                r_q1 <= i_cfg_data;
            end else begin
                r_q2 <= i_cfg_data;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (i_cmd.idle) begin
                r_out_data <= '0;
            end else begin
                r_out_data.ran              <= 1'b1;
                r_out_data.served_process   <= 3'(r_pid);
                r_out_data.was_io           <= x_io;
                r_out_data.served_level     <= x_lvl;
                r_out_data.run_amount       <= x_run[9:0];
                r_out_data.destination      <= x_dest;
                r_out_data.next_burst_index <= 6'(x_npos);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hdl/three_level_feedback_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler_core
// Three-level feedback queue scheduler with an I/O wait queue.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// i_in      sink       load one burst or request one scheduling step
// o_out     source     one result word per step, none per load
// i_cfg_*   write      quantum of the top (index 0) or middle (index 1) level
//
// A load is written on acceptance. After acceptance a step enters the pick state,
// which pops one queue head per pick until a live process is popped (each finished
// process skipped is popped too) or nothing is left to pick; the burst store read
// sits between pop and execute.
// The execute cycle waits while the output register still holds a word.
// Synchronous reset empties all queues and tables; the burst store is not cleared.
module three_level_feedback_scheduler_core #(
    parameter int NUM_PROCESSES = 8,
    parameter int MAX_BURSTS    = 32,
    parameter int BURST_WIDTH   = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlfs_in_if.sink           i_in,
    tlfs_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    tlfs_pkg::t_cmd    cmd;
    tlfs_pkg::t_status status;

    tlfs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.data.command),
        .i_status     (status),
        .o_in_ready   (i_in.ready),
        .o_cmd        (cmd)
    );

    tlfs_dpath #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .MAX_BURSTS    (MAX_BURSTS),
        .BURST_WIDTH   (BURST_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

endmodule

@@ hdl/tlfs_checker.sv @@
// ----------------------------------------------------------------------------
// tlfs_checker
// Port-level checks of the scheduler's result words.
// ----------------------------------------------------------------------------
`include "three_level_feedback_scheduler_core_macros.svh"

module tlfs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input tlfs_pkg::t_out_word i_out_data
);

    // A stalled result word holds.
    `TLFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // An idle step reports all fields zero.
    `TLFS_ASSERT_IMPLY(a_idle_zero, i_clk, i_rst_n, i_out_valid && !i_out_data.ran, i_out_data == '0)

    // After an I/O burst the next burst is CPU work, never the wait queue.
    `TLFS_ASSERT_IMPLY(a_io_route, i_clk, i_rst_n, i_out_valid && i_out_data.ran && i_out_data.was_io, i_out_data.destination != tlfs_pkg::DEST_WAIT)

    // A bottom-level CPU burst always completes, so it goes to I/O or ends.
    `TLFS_ASSERT_IMPLY(a_bottom_route, i_clk, i_rst_n, i_out_valid && i_out_data.ran && !i_out_data.was_io && i_out_data.served_level == tlfs_pkg::Q_BOT, i_out_data.destination == tlfs_pkg::DEST_WAIT || i_out_data.destination == tlfs_pkg::DEST_TERM)

endmodule

bind three_level_feedback_scheduler_core tlfs_checker u_tlfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
